// ===== design/cblt_pkg.sv =====
// Package for the copy-back limit table.
// Holds widths, register indexes and controller/datapath command and status types.
// No dependencies.
package cblt_pkg;

	// default table size
	localparam int DEFAULT_CAPACITY = 16;

	// field widths
	localparam int ADDR_W    = 32;
	localparam int COUNT_W   = 8;
	localparam int USED_W    = 5;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 8;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_REPEATS = 1'b0,
		REG_MAX_ENTRIES = 1'b1
	} cfg_reg_t;

	// item operation codes
	typedef enum logic {
		OP_COPY_BACK = 1'b0,
		OP_ECC_CLEAR = 1'b1
	} op_t;

	// controller to datapath
	typedef struct packed {
		logic load;    // capture the incoming request, restart the scan
		logic scan;    // issue the read of the current entry
		logic commit;  // update the table and register the result
	} cblt_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_last;  // current scan index is the last entry
		logic out_busy;   // result register holds a result that is not being taken
	} cblt_status_t;

endpackage

// ===== design/cblt_if.sv =====
// Valid/ready channel interfaces for the copy-back limit table.
// Request, response and configuration write channels.
// Depends on cblt_pkg.
interface cblt_in_if import cblt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              op;
	logic [ADDR_W-1:0] page_address;

	modport source (output valid, output op, output page_address, input ready);
	modport sink   (input valid, input op, input page_address, output ready);
endinterface

interface cblt_out_if import cblt_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               allowed;
	logic [COUNT_W-1:0] repeat_count;
	logic [USED_W-1:0]  entries_used;

	modport source (output valid, output allowed, output repeat_count, output entries_used,
		input ready);
	modport sink   (input valid, input allowed, input repeat_count, input entries_used,
		output ready);
endinterface

interface cblt_cfg_if import cblt_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/cblt_ctrl.sv =====
// Controller state machine of the copy-back limit table.
// Sequences accept, entry scan, flush and commit; drives request ready.
// Depends on cblt_pkg.
module cblt_ctrl import cblt_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  cblt_status_t status,
	output cblt_cmd_t    cmd
);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SCAN   = 4'b0010,
		S_FLUSH  = 4'b0100,
		S_DECIDE = 4'b1000
	} state_t;

	state_t state_q, state_d;

	// next state and commands
	always_comb begin
		state_d    = state_q;
		cmd.load   = 1'b0;
		cmd.scan   = 1'b0;
		cmd.commit = 1'b0;
		in_ready   = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (status.scan_last) begin
					state_d = S_FLUSH;
				end
			end
			S_FLUSH: begin
				// last read compares during this cycle
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (!status.out_busy) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== design/cblt_datapath.sv =====
// Datapath of the copy-back limit table.
// Entry memories, valid bits, scan compare, occupancy, config and result registers.
// Depends on cblt_pkg and cblt_if.
module cblt_datapath import cblt_pkg::*; #(
	parameter int CAPACITY = DEFAULT_CAPACITY
) (
	input  logic          clk,
	input  logic          arst_n,
	cblt_cfg_if.sink      cfg,
	input  logic          in_op,
	input  logic [ADDR_W-1:0] in_addr,
	cblt_out_if.source    rsp,
	input  cblt_cmd_t     cmd,
	output cblt_status_t  status
);

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int LW = ((CW > USED_W) ? CW : USED_W) + 1;

	// configuration registers
	logic [COUNT_W-1:0] max_repeats_q;
	logic [USED_W-1:0]  max_entries_q;

	// table storage
	logic [ADDR_W-1:0]  addr_mem [CAPACITY];
	logic [COUNT_W-1:0] cnt_mem  [CAPACITY];
	logic [CAPACITY-1:0] valid_q;
	logic [CW-1:0]      used_q;

	// captured request and scan state
	logic               op_q;
	logic [ADDR_W-1:0]  key_q;
	logic [CW-1:0]      scan_idx_q;
	logic               rd_en_s1;
	logic               rd_vld_s1;
	logic [IW-1:0]      rd_idx_s1;
	logic [ADDR_W-1:0]  rd_addr_s1;
	logic [COUNT_W-1:0] rd_cnt_s1;
	logic               hit_q;
	logic [IW-1:0]      hit_idx_q;
	logic [COUNT_W-1:0] hit_cnt_q;
	logic               free_q;
	logic [IW-1:0]      free_idx_q;

	// result register
	logic               out_valid_q;
	logic               out_allowed_q;
	logic [COUNT_W-1:0] out_count_q;
	logic [USED_W-1:0]  out_used_q;

	// decision signals
	logic [LW-1:0]      limit;
	logic               enabled;
	logic               do_clear;
	logic               do_incr;
	logic               do_insert;
	logic               allowed_d;
	logic [COUNT_W-1:0] count_d;
	logic [CW-1:0]      used_d;

	assign cfg.ready = 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_repeats_q <= '0;
			max_entries_q <= '0;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_MAX_REPEATS: max_repeats_q <= cfg.data;
				REG_MAX_ENTRIES: max_entries_q <= cfg.data[USED_W-1:0];
				default: ;
			endcase
		end
	end

	// decision for the committed request
	always_comb begin
		limit = (LW'(max_entries_q) > LW'(CAPACITY)) ? LW'(CAPACITY) : LW'(max_entries_q);
		enabled   = (max_repeats_q != '0) && (limit != '0);
		do_clear  = 1'b0;
		do_incr   = 1'b0;
		do_insert = 1'b0;
		allowed_d = 1'b0;
		count_d   = '0;
		used_d    = used_q;
		if (op_t'(op_q) == OP_ECC_CLEAR) begin
			if (hit_q) begin
				do_clear = 1'b1;
				used_d   = used_q - CW'(1);
			end
		end else if (enabled) begin
			if (hit_q) begin
				count_d = hit_cnt_q;
				if (hit_cnt_q < max_repeats_q) begin
					do_incr   = 1'b1;
					allowed_d = 1'b1;
					count_d   = hit_cnt_q + COUNT_W'(1);
				end
			end else if ((LW'(used_q) < limit) && free_q) begin
				do_insert = 1'b1;
				allowed_d = 1'b1;
				count_d   = COUNT_W'(1);
				used_d    = used_q + CW'(1);
			end
		end else if (hit_q) begin
			count_d = hit_cnt_q;
		end
	end

	// entry memories: registered scan read, one write port
	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			rd_addr_s1 <= addr_mem[scan_idx_q[IW-1:0]];
			rd_cnt_s1  <= cnt_mem[scan_idx_q[IW-1:0]];
			rd_idx_s1  <= scan_idx_q[IW-1:0];
			rd_vld_s1  <= valid_q[scan_idx_q[IW-1:0]];
		end
		if (cmd.commit && do_insert) begin
			addr_mem[free_idx_q] <= key_q;
			cnt_mem[free_idx_q]  <= COUNT_W'(1);
		end else if (cmd.commit && do_incr) begin
			cnt_mem[hit_idx_q] <= count_d;
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= in_op;
			key_q <= in_addr;
		end
	end

	// scan index, compare and search flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
			rd_en_s1   <= 1'b0;
			hit_q      <= 1'b0;
			free_q     <= 1'b0;
			hit_idx_q  <= '0;
			hit_cnt_q  <= '0;
			free_idx_q <= '0;
		end else begin
			rd_en_s1 <= cmd.scan;
			if (cmd.load) begin
				scan_idx_q <= '0;
				hit_q      <= 1'b0;
				free_q     <= 1'b0;
			end else begin
				if (cmd.scan) begin
					scan_idx_q <= scan_idx_q + CW'(1);
				end
				if (rd_en_s1) begin
					if (rd_vld_s1 && (rd_addr_s1 == key_q) && !hit_q) begin
						hit_q     <= 1'b1;
						hit_idx_q <= rd_idx_s1;
						hit_cnt_q <= rd_cnt_s1;
					end
					if (!rd_vld_s1 && !free_q) begin
						free_q     <= 1'b1;
						free_idx_q <= rd_idx_s1;
					end
				end
			end
		end
	end

	// valid bits and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			used_q  <= '0;
		end else if (cmd.commit) begin
			used_q <= used_d;
			if (do_clear) begin
				valid_q[hit_idx_q] <= 1'b0;
			end else if (do_insert) begin
				valid_q[free_idx_q] <= 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_allowed_q <= allowed_d;
			out_count_q   <= count_d;
			out_used_q    <= USED_W'(used_d);
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.allowed      = out_allowed_q;
	assign rsp.repeat_count = out_count_q;
	assign rsp.entries_used = out_used_q;

	assign status.scan_last = (scan_idx_q == CW'(CAPACITY - 1));
	assign status.out_busy  = out_valid_q && !rsp.ready;

endmodule

// ===== design/copy_back_limit_table.sv =====
// Top level of the copy-back limit table.
// Instantiates the controller and the datapath.
// Depends on cblt_pkg, cblt_if, cblt_ctrl and cblt_datapath.
//
// Usage:
//   req  : request channel; op 0 asks for a copy-back of page_address (recorded
//          when allowed), op 1 reports an ECC check and removes the address.
//   rsp  : one response per request: allowed, repeat_count, entries_used.
//   cfg  : register writes, index 0 max_repeats, index 1 max_entries; always ready.
//          Write only while no request is in flight.
// Sequence:
//   A request is accepted in the idle state, then the table is scanned one entry
//   per cycle through the registered memory read, then comes the flush state,
//   and then the decide state, which commits. The response is registered at the
//   commit; a new request is taken only after the return to the idle state.
// Reset: clears the valid bits at once (table empty) and both limit registers.
// Stall: the response register holds while rsp.ready is low; the next request is
//   still accepted and scanned, and waits at commit until the response is taken.
module copy_back_limit_table import cblt_pkg::*; #(
	parameter int CAPACITY = DEFAULT_CAPACITY
) (
	input  logic       clk,
	input  logic       arst_n,
	cblt_cfg_if.sink   cfg,
	cblt_in_if.sink    req,
	cblt_out_if.source rsp
);

	cblt_cmd_t    cmd;
	cblt_status_t status;

	cblt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.status   (status),
		.cmd      (cmd)
	);

	cblt_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.in_op   (req.op),
		.in_addr (req.page_address),
		.rsp     (rsp),
		.cmd     (cmd),
		.status  (status)
	);

endmodule

// ===== design/cblt_checker.sv =====
// Port-level checker for the copy-back limit table, with its bind statement.
// Watches the request and response channels of the top level.
// Depends on cblt_pkg.
module cblt_checker import cblt_pkg::*; #(
	parameter int CAPACITY = DEFAULT_CAPACITY
) (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic               out_allowed,
	input logic [COUNT_W-1:0] out_count,
	input logic [USED_W-1:0]  out_used
);

	// a stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_allowed)
			&& $stable(out_count) && $stable(out_used))
		else $error("response changed while stalled");

	// an allowed copy-back always reports a nonzero count and a nonempty table
	a_allowed_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_allowed |-> (out_count != '0) && (out_used != '0))
		else $error("allowed response with zero count or empty table");

	// occupancy stays within the table
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((CAPACITY > 31) || (int'(out_used) <= CAPACITY)))
		else $error("occupancy above capacity");

	// one request at a time: the scan keeps the request side closed
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted during a scan");

endmodule

bind copy_back_limit_table cblt_checker #(
	.CAPACITY (CAPACITY)
) u_cblt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (req.valid),
	.in_ready    (req.ready),
	.out_valid   (rsp.valid),
	.out_ready   (rsp.ready),
	.out_allowed (rsp.allowed),
	.out_count   (rsp.repeat_count),
	.out_used    (rsp.entries_used)
);
